// ===== rtl/core/km_pkg.sv =====
// Package: shared codes, types and fixed widths for the k-means block.
`timescale 1ns / 1ps
package km_pkg;
	localparam int REQ_W = 3;
	localparam int CFG_DATA_W = 8;
	localparam int CFG_K_W = 4;
	localparam int CFG_LIM_W = 8;
	localparam int PASS_W = 8;
	localparam int FRAC_BITS = 8;

	typedef logic [REQ_W-1:0] req_t;

	localparam req_t REQ_CLEAR = 3'd0;
	localparam req_t REQ_LOAD_POINT = 3'd1;
	localparam req_t REQ_LOAD_SEED = 3'd2;
	localparam req_t REQ_RUN = 3'd3;
	localparam req_t REQ_QUERY = 3'd4;

	localparam logic REG_CLUSTER_COUNT = 1'b0;
	localparam logic REG_ITERATION_LIMIT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FEED,
		ST_DRAIN,
		ST_DIV_CHK,
		ST_DIV_X,
		ST_DIV_Y,
		ST_EMIT,
		ST_QOUT
	} km_state_t;
endpackage

// ===== rtl/core/km_if.sv =====
// Interfaces: request and result channels with valid/ready handshake.
`timescale 1ns / 1ps
interface km_req_if #(parameter int COORD_BITS = 16, parameter int PIDX_W = 8);
	import km_pkg::*;
	logic valid;
	logic ready;
	req_t req_type;
	logic signed [COORD_BITS-1:0] coord_x;
	logic signed [COORD_BITS-1:0] coord_y;
	logic [PIDX_W-1:0] point_index;
	modport source(output valid, req_type, coord_x, coord_y, point_index, input ready);
	modport sink(input valid, req_type, coord_x, coord_y, point_index, output ready);
endinterface

interface km_res_if #(
	parameter int CIDX_W = 3,
	parameter int MEAN_W = 24,
	parameter int CNT_W = 9,
	parameter int PASS_W = 8
);
	logic valid;
	logic ready;
	logic [CIDX_W-1:0] cluster_index;
	logic signed [MEAN_W-1:0] mean_x;
	logic signed [MEAN_W-1:0] mean_y;
	logic [CNT_W-1:0] member_count;
	logic [PASS_W-1:0] passes_done;
	logic converged;
	logic last;
	modport source(output valid, cluster_index, mean_x, mean_y, member_count, passes_done,
		converged, last, input ready);
	modport sink(input valid, cluster_index, mean_x, mean_y, member_count, passes_done,
		converged, last, output ready);
endinterface

// ===== rtl/core/km_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned operands.
`timescale 1ns / 1ps
module km_div #(
	parameter int DVD_W = 33,
	parameter int DSR_W = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DSR_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);
	localparam int CW = $clog2(DVD_W + 1);

	logic [CW-1:0] cnt_q;
	logic run_q;
	logic done_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVD_W-1:0] quo_q;
	logic [DSR_W:0] rem_q;
	logic [DSR_W-1:0] dsr_q;
	logic [DSR_W:0] rem_sh;
	logic take;

	assign rem_sh = {rem_q[DSR_W-1:0], dvd_q[DVD_W-1]};
	assign take = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(DVD_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= take ? rem_sh - {1'b0, dsr_q} : rem_sh;
			quo_q <= {quo_q[DVD_W-2:0], take};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
endmodule

// ===== rtl/core/km_cell.sv =====
// Cluster cell: holds one mean and its accumulators, scores passing points.
`timescale 1ns / 1ps
module km_cell #(
	parameter int IDX = 0,
	parameter int COORD_BITS = 16,
	parameter int MEAN_W = 24,
	parameter int SUM_W = 25,
	parameter int CNT_W = 9,
	parameter int CIDX_W = 3,
	parameter int D_W = 50
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         clr,
	input  logic                         mean_we,
	input  logic signed [MEAN_W-1:0]     mean_x_in,
	input  logic signed [MEAN_W-1:0]     mean_y_in,
	input  logic                         acc_v,
	input  logic [CIDX_W-1:0]            acc_idx,
	input  logic signed [COORD_BITS-1:0] acc_px,
	input  logic signed [COORD_BITS-1:0] acc_py,
	input  logic                         v_in,
	input  logic signed [COORD_BITS-1:0] px_in,
	input  logic signed [COORD_BITS-1:0] py_in,
	input  logic [D_W-1:0]               bd_in,
	input  logic [CIDX_W-1:0]            bi_in,
	output logic                         v_out,
	output logic signed [COORD_BITS-1:0] px_out,
	output logic signed [COORD_BITS-1:0] py_out,
	output logic [D_W-1:0]               bd_out,
	output logic [CIDX_W-1:0]            bi_out,
	output logic signed [MEAN_W-1:0]     mean_x,
	output logic signed [MEAN_W-1:0]     mean_y,
	output logic signed [SUM_W-1:0]      sum_x,
	output logic signed [SUM_W-1:0]      sum_y,
	output logic [CNT_W-1:0]             cnt
);
	import km_pkg::*;

	localparam logic [CIDX_W-1:0] MY_IDX = CIDX_W'(IDX);
	localparam int SQ_W = 2 * MEAN_W + 1;

	logic signed [MEAN_W-1:0] mx_q, my_q;
	logic signed [SUM_W-1:0] sx_q, sy_q;
	logic [CNT_W-1:0] cnt_q;

	logic signed [MEAN_W-1:0] pxe, pye;
	logic signed [MEAN_W:0] dx, dy;
	logic signed [2*MEAN_W+1:0] sqx, sqy;

	logic v_s1, v_s2;
	logic signed [COORD_BITS-1:0] px_s1, py_s1, px_s2, py_s2;
	logic [D_W-1:0] bd_s1, bd_s2;
	logic [CIDX_W-1:0] bi_s1, bi_s2;
	logic [SQ_W-1:0] sqx_s1, sqy_s1;
	logic [D_W-1:0] d;
	logic win;

	assign pxe = {px_in, FRAC_BITS'(0)};
	assign pye = {py_in, FRAC_BITS'(0)};
	assign dx = {pxe[MEAN_W-1], pxe} - {mx_q[MEAN_W-1], mx_q};
	assign dy = {pye[MEAN_W-1], pye} - {my_q[MEAN_W-1], my_q};
	assign sqx = dx * dx;
	assign sqy = dy * dy;

	assign d = D_W'(sqx_s1) + D_W'(sqy_s1);
	// lowest index wins ties: only a strictly smaller distance takes over
	assign win = en && ((IDX == 0) || (d < bd_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		px_s1 <= px_in;
		py_s1 <= py_in;
		bd_s1 <= bd_in;
		bi_s1 <= bi_in;
		sqx_s1 <= sqx[SQ_W-1:0];
		sqy_s1 <= sqy[SQ_W-1:0];
		px_s2 <= px_s1;
		py_s2 <= py_s1;
		bd_s2 <= win ? d : bd_s1;
		bi_s2 <= win ? MY_IDX : bi_s1;
	end

	always_ff @(posedge clk) begin
		if (mean_we) begin
			mx_q <= mean_x_in;
			my_q <= mean_y_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q <= '0;
			sy_q <= '0;
			cnt_q <= '0;
		end else if (clr) begin
			sx_q <= '0;
			sy_q <= '0;
			cnt_q <= '0;
		end else if (acc_v && acc_idx == MY_IDX) begin
			sx_q <= sx_q + SUM_W'(acc_px);
			sy_q <= sy_q + SUM_W'(acc_py);
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign v_out = v_s2;
	assign px_out = px_s2;
	assign py_out = py_s2;
	assign bd_out = bd_s2;
	assign bi_out = bi_s2;
	assign mean_x = mx_q;
	assign mean_y = my_q;
	assign sum_x = sx_q;
	assign sum_y = sy_q;
	assign cnt = cnt_q;
endmodule

// ===== rtl/core/kmeans_2d_clustering.sv =====
// Top level: Lloyd k-means over a chain of cluster cells with a shared divider.
// A query reads the assignment store, then its result is registered in ST_QOUT once the output is free.
// A pass streams the stored points through the cell chain, then checks each of the k clusters in turn
// and runs the divider on x, then y, of each non-empty cluster (DVD_W = 33 by default).
// After the last pass, k results follow one per cycle while taken; no request during a run or query.
// Reset clears counters, accumulators, config to k=2 and limit 32; point and mean stores are not cleared.
`timescale 1ns / 1ps
module kmeans_2d_clustering #(
	parameter int MAX_POINTS = 256,
	parameter int MAX_CLUSTERS = 8,
	parameter int COORD_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [km_pkg::CFG_DATA_W-1:0] cfg_wdata,
	km_req_if.sink                    req,
	km_res_if.source                  res
);
	import km_pkg::*;

	localparam int PIDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int CIDX_W = $clog2(MAX_CLUSTERS);
	localparam int KCNT_W = $clog2(MAX_CLUSTERS + 1);
	localparam int MEAN_W = COORD_BITS + FRAC_BITS;
	localparam int SUM_W = COORD_BITS + PIDX_W + 1;
	localparam int DVD_W = SUM_W + FRAC_BITS;
	localparam int D_W = 2 * MEAN_W + 2;
	localparam int NC = MAX_CLUSTERS;

	km_state_t state_q, state_d;

	logic [CFG_K_W-1:0] cfg_k_q;
	logic [CFG_LIM_W-1:0] cfg_lim_q;
	logic [KCNT_W-1:0] k_eff, k_q, k_cur, j_q, seeds_q;
	logic [CFG_LIM_W-1:0] lim_q;
	logic [PASS_W-1:0] passes_q;
	logic [CNT_W-1:0] points_q, assigned_q, issue_q, retire_q;
	logic [PIDX_W-1:0] qidx_q;
	logic moved_q, conv_q;
	logic signed [MEAN_W-1:0] nx_q;

	logic signed [COORD_BITS-1:0] pxmem [MAX_POINTS];
	logic signed [COORD_BITS-1:0] pymem [MAX_POINTS];
	logic [CIDX_W-1:0] amem [MAX_POINTS];
	logic signed [COORD_BITS-1:0] px_rd_s1, py_rd_s1;
	logic rdv_s1;
	logic [CIDX_W-1:0] arow_s1;

	logic in_acc, out_free;
	logic pt_rd, pass_start, dx_start, dy_start, mean_upd, j_inc, j_clr;
	logic emit, q_out, to_emit, q_rd, clr_all;

	logic fv [NC+1];
	logic signed [COORD_BITS-1:0] fpx [NC+1];
	logic signed [COORD_BITS-1:0] fpy [NC+1];
	logic [D_W-1:0] fbd [NC+1];
	logic [CIDX_W-1:0] fbi [NC+1];
	logic signed [MEAN_W-1:0] cmx [NC];
	logic signed [MEAN_W-1:0] cmy [NC];
	logic signed [SUM_W-1:0] csx [NC];
	logic signed [SUM_W-1:0] csy [NC];
	logic [CNT_W-1:0] ccnt [NC];
	logic [NC-1:0] mwe;
	logic signed [MEAN_W-1:0] wmx, wmy;

	logic [CIDX_W-1:0] rsel, qc;
	logic q_inrange;
	logic signed [SUM_W-1:0] dsum;
	logic dneg;
	logic [SUM_W-1:0] dmag;
	logic div_done;
	logic [DVD_W-1:0] div_q;
	logic signed [DVD_W-1:0] sq_res;
	logic signed [MEAN_W-1:0] div_mean;
	logic seed_we;

	assign in_acc = req.valid && req.ready;
	assign out_free = !res.valid || res.ready;

	always_comb begin
		if (cfg_k_q == '0) k_eff = KCNT_W'(1);
		else if (int'(cfg_k_q) > MAX_CLUSTERS) k_eff = KCNT_W'(MAX_CLUSTERS);
		else k_eff = KCNT_W'(cfg_k_q);
	end
	assign k_cur = (state_q == ST_IDLE) ? k_eff : k_q;

	// sequencer
	always_comb begin
		state_d = state_q;
		req.ready = 1'b0;
		pt_rd = 1'b0;
		pass_start = 1'b0;
		dx_start = 1'b0;
		dy_start = 1'b0;
		mean_upd = 1'b0;
		j_inc = 1'b0;
		j_clr = 1'b0;
		emit = 1'b0;
		q_out = 1'b0;
		q_rd = 1'b0;
		to_emit = 1'b0;
		clr_all = 1'b0;
		seed_we = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (in_acc) begin
					case (req.req_type)
						REQ_CLEAR: clr_all = 1'b1;
						REQ_LOAD_SEED: seed_we = int'(seeds_q) < MAX_CLUSTERS;
						REQ_RUN: begin
							pass_start = 1'b1;
							state_d = ST_FEED;
						end
						REQ_QUERY: begin
							q_rd = 1'b1;
							state_d = ST_QOUT;
						end
						default: ;
					endcase
				end
			end
			ST_FEED: begin
				if (issue_q < points_q) pt_rd = 1'b1;
				else state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (retire_q == points_q) begin
					j_clr = 1'b1;
					state_d = ST_DIV_CHK;
				end
			end
			ST_DIV_CHK: begin
				if (j_q == k_q) begin
					if (!moved_q || passes_q == lim_q) begin
						to_emit = 1'b1;
						j_clr = 1'b1;
						state_d = ST_EMIT;
					end else begin
						pass_start = 1'b1;
						state_d = ST_FEED;
					end
				end else if (ccnt[rsel] == '0) begin
					j_inc = 1'b1;
				end else begin
					dx_start = 1'b1;
					state_d = ST_DIV_X;
				end
			end
			ST_DIV_X: begin
				if (div_done) begin
					dy_start = 1'b1;
					state_d = ST_DIV_Y;
				end
			end
			ST_DIV_Y: begin
				if (div_done) begin
					mean_upd = 1'b1;
					j_inc = 1'b1;
					state_d = ST_DIV_CHK;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					emit = 1'b1;
					j_inc = 1'b1;
					if (j_q == k_q - 1'b1) state_d = ST_IDLE;
				end
			end
			ST_QOUT: begin
				if (out_free) begin
					q_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_k_q <= CFG_K_W'(2);
			cfg_lim_q <= CFG_LIM_W'(32);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CLUSTER_COUNT: cfg_k_q <= cfg_wdata[CFG_K_W-1:0];
				REG_ITERATION_LIMIT: cfg_lim_q <= cfg_wdata[CFG_LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_q <= '0;
			seeds_q <= '0;
			assigned_q <= '0;
			issue_q <= '0;
			retire_q <= '0;
			passes_q <= '0;
			k_q <= KCNT_W'(1);
			lim_q <= CFG_LIM_W'(1);
			j_q <= '0;
			moved_q <= 1'b0;
			conv_q <= 1'b0;
			rdv_s1 <= 1'b0;
		end else begin
			rdv_s1 <= pt_rd;
			if (clr_all) begin
				points_q <= '0;
				seeds_q <= '0;
				assigned_q <= '0;
			end
			if (in_acc && req.req_type == REQ_LOAD_POINT && int'(points_q) < MAX_POINTS)
				points_q <= points_q + 1'b1;
			if (seed_we) seeds_q <= seeds_q + 1'b1;
			if (state_q == ST_IDLE && pass_start) begin
				k_q <= k_eff;
				lim_q <= (cfg_lim_q == '0) ? CFG_LIM_W'(1) : cfg_lim_q;
				passes_q <= PASS_W'(1);
			end else if (pass_start) begin
				passes_q <= passes_q + 1'b1;
			end
			if (pass_start) begin
				issue_q <= '0;
				retire_q <= '0;
				moved_q <= 1'b0;
			end else begin
				if (pt_rd) issue_q <= issue_q + 1'b1;
				if (fv[NC]) retire_q <= retire_q + 1'b1;
			end
			if (state_q == ST_DRAIN && j_clr) assigned_q <= points_q;
			if (j_clr) j_q <= '0;
			else if (j_inc) j_q <= j_q + 1'b1;
			if (mean_upd && (nx_q != cmx[rsel] || div_mean != cmy[rsel])) moved_q <= 1'b1;
			if (to_emit) conv_q <= !moved_q;
		end
	end

	// point and assignment stores
	always_ff @(posedge clk) begin
		if (in_acc && req.req_type == REQ_LOAD_POINT && int'(points_q) < MAX_POINTS) begin
			pxmem[points_q[PIDX_W-1:0]] <= req.coord_x;
			pymem[points_q[PIDX_W-1:0]] <= req.coord_y;
		end
		if (pt_rd) begin
			px_rd_s1 <= pxmem[issue_q[PIDX_W-1:0]];
			py_rd_s1 <= pymem[issue_q[PIDX_W-1:0]];
		end
		if (fv[NC]) amem[retire_q[PIDX_W-1:0]] <= fbi[NC];
		if (q_rd) begin
			arow_s1 <= amem[req.point_index];
			qidx_q <= req.point_index;
		end
	end

	// cell chain
	assign fv[0] = rdv_s1;
	assign fpx[0] = px_rd_s1;
	assign fpy[0] = py_rd_s1;
	assign fbd[0] = '0;
	assign fbi[0] = '0;

	assign wmx = seed_we ? MEAN_W'({req.coord_x, FRAC_BITS'(0)}) : nx_q;
	assign wmy = seed_we ? MEAN_W'({req.coord_y, FRAC_BITS'(0)}) : div_mean;

	for (genvar i = 0; i < NC; i++) begin : g_cell
		assign mwe[i] = (seed_we && seeds_q[CIDX_W-1:0] == CIDX_W'(i))
			|| (mean_upd && rsel == CIDX_W'(i));
		km_cell #(
			.IDX(i), .COORD_BITS(COORD_BITS), .MEAN_W(MEAN_W), .SUM_W(SUM_W),
			.CNT_W(CNT_W), .CIDX_W(CIDX_W), .D_W(D_W)
		) u_cell (
			.clk(clk), .arst_n(arst_n),
			.en(int'(k_cur) > i),
			.clr(clr_all || (pass_start && int'(k_cur) > i)),
			.mean_we(mwe[i]), .mean_x_in(wmx), .mean_y_in(wmy),
			.acc_v(fv[NC]), .acc_idx(fbi[NC]), .acc_px(fpx[NC]), .acc_py(fpy[NC]),
			.v_in(fv[i]), .px_in(fpx[i]), .py_in(fpy[i]), .bd_in(fbd[i]), .bi_in(fbi[i]),
			.v_out(fv[i+1]), .px_out(fpx[i+1]), .py_out(fpy[i+1]),
			.bd_out(fbd[i+1]), .bi_out(fbi[i+1]),
			.mean_x(cmx[i]), .mean_y(cmy[i]), .sum_x(csx[i]), .sum_y(csy[i]), .cnt(ccnt[i])
		);
	end

	// mean update: |sum| * 256 / count, sign restored (truncates toward zero)
	assign q_inrange = qidx_q < assigned_q;
	assign qc = q_inrange ? arow_s1 : '0;
	assign rsel = (state_q == ST_QOUT) ? qc : j_q[CIDX_W-1:0];

	assign dsum = dy_start ? csy[rsel] : csx[rsel];
	assign dneg = dsum[SUM_W-1];
	assign dmag = dneg ? SUM_W'(-dsum) : SUM_W'(dsum);

	logic neg_q;
	always_ff @(posedge clk) begin
		if (dx_start || dy_start) neg_q <= dneg;
		if (state_q == ST_DIV_X && div_done) nx_q <= div_mean;
	end
	assign sq_res = neg_q ? -$signed(div_q) : $signed(div_q);
	assign div_mean = sq_res[MEAN_W-1:0];

	km_div #(.DVD_W(DVD_W), .DSR_W(CNT_W)) u_div (
		.clk(clk), .arst_n(arst_n),
		.start(dx_start || dy_start),
		.dividend({dmag, FRAC_BITS'(0)}),
		.divisor(ccnt[rsel]),
		.done(div_done),
		.quotient(div_q)
	);

	// result register
	logic out_v_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (emit || q_out) out_v_q <= 1'b1;
		else if (res.ready) out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res.cluster_index <= rsel;
			res.mean_x <= cmx[rsel];
			res.mean_y <= cmy[rsel];
			res.member_count <= ccnt[rsel];
			res.passes_done <= passes_q;
			res.converged <= conv_q;
			res.last <= (j_q == k_q - 1'b1);
		end else if (q_out) begin
			res.cluster_index <= (qidx_q < points_q) ? qc : '0;
			res.mean_x <= (qidx_q < points_q) ? cmx[rsel] : '0;
			res.mean_y <= (qidx_q < points_q) ? cmy[rsel] : '0;
			res.member_count <= (qidx_q < points_q) ? ccnt[rsel] : '0;
			res.passes_done <= '0;
			res.converged <= 1'b0;
			res.last <= 1'b1;
		end
	end
	assign res.valid = out_v_q;

	a_retire_le_issue: assert property (@(posedge clk) disable iff (!arst_n)
		retire_q <= issue_q)
		else $error("chain retired more points than issued");
	a_exit_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		fv[NC] |-> (state_q == ST_FEED || state_q == ST_DRAIN))
		else $error("chain output outside a pass");
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV_X || state_q == ST_DIV_Y))
		else $error("divider finished outside mean update");
	a_emit_from_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (j_q < k_q))
		else $error("result emitted for cluster beyond k");
endmodule

// ===== bench/kmeans_2d_clustering_test.sv =====
// Testbench: checks loads, runs and queries of the k-means block against a built-in predictor.
`timescale 1ns / 1ps
module kmeans_2d_clustering_test;
	import km_pkg::*;

	localparam int NPTS = 256;
	localparam int NCLU = 8;
	localparam int CYCLE_LIMIT = 20000000;
	localparam int SETTLE = 40;

	typedef struct {
		req_t req_type;
		logic signed [15:0] coord_x;
		logic signed [15:0] coord_y;
		logic [7:0] point_index;
	} request_t;

	typedef struct {
		logic [2:0] cluster_index;
		logic [23:0] mean_x;
		logic [23:0] mean_y;
		logic [8:0] member_count;
		logic [7:0] passes_done;
		logic converged;
		logic last;
	} result_t;

	class km_scoreboard;
		int unsigned k_reg;
		int unsigned limit_reg;
		longint pt_x[NPTS];
		longint pt_y[NPTS];
		int unsigned member_of[NPTS];
		longint cen_x[NCLU];
		longint cen_y[NCLU];
		longint acc_x[NCLU];
		longint acc_y[NCLU];
		int unsigned acc_n[NCLU];
		int unsigned n_points;
		int unsigned n_seeds;
		result_t expected_results[$];
		int errors;

		function new();
			k_reg = 2;
			limit_reg = 32;
			foreach (pt_x[i]) begin
				pt_x[i] = 0;
				pt_y[i] = 0;
			end
			foreach (cen_x[j]) begin
				cen_x[j] = 0;
				cen_y[j] = 0;
			end
			clear_work();
			errors = 0;
		endfunction

		function void write_config(logic idx, logic [7:0] v);
			if (idx == REG_CLUSTER_COUNT)
				k_reg = v[3:0];
			else
				limit_reg = v;
		endfunction

		function void clear_work();
			n_points = 0;
			n_seeds = 0;
			foreach (member_of[i]) member_of[i] = 0;
			foreach (acc_x[j]) begin
				acc_x[j] = 0;
				acc_y[j] = 0;
				acc_n[j] = 0;
			end
		endfunction

		function void push(int unsigned c, longint mx, longint my, int unsigned n,
				int unsigned passes, bit conv, bit lst);
			result_t r;
			r.cluster_index = c[2:0];
			r.mean_x = mx[23:0];
			r.mean_y = my[23:0];
			r.member_count = n[8:0];
			r.passes_done = passes[7:0];
			r.converged = conv;
			r.last = lst;
			expected_results.insert(expected_results.size(), r);
		endfunction

		function longint dist2(longint ax, longint ay, longint bx, longint by);
			return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
		endfunction

		function void lloyd_run();
			int unsigned k, lim, passes, best;
			bit conv, moved;
			longint bd, d, nx, ny;
			k = (k_reg == 0) ? 1 : (k_reg > NCLU ? NCLU : k_reg);
			lim = (limit_reg == 0) ? 1 : limit_reg;
			passes = 0;
			conv = 0;
			while (passes < lim) begin
				moved = 0;
				passes++;
				for (int j = 0; j < k; j++) begin
					acc_x[j] = 0;
					acc_y[j] = 0;
					acc_n[j] = 0;
				end
				for (int i = 0; i < n_points; i++) begin
					best = 0;
					bd = dist2(pt_x[i] * 256, pt_y[i] * 256, cen_x[0], cen_y[0]);
					for (int j = 1; j < k; j++) begin
						d = dist2(pt_x[i] * 256, pt_y[i] * 256, cen_x[j], cen_y[j]);
						if (d < bd) begin
							bd = d;
							best = j;
						end
					end
					member_of[i] = best;
					acc_x[best] += pt_x[i];
					acc_y[best] += pt_y[i];
					acc_n[best]++;
				end
				for (int j = 0; j < k; j++) begin
					if (acc_n[j] != 0) begin
						nx = (acc_x[j] * 256) / longint'(acc_n[j]);
						ny = (acc_y[j] * 256) / longint'(acc_n[j]);
						if (nx != cen_x[j] || ny != cen_y[j]) moved = 1;
						cen_x[j] = nx;
						cen_y[j] = ny;
					end
				end
				if (!moved) begin
					conv = 1;
					break;
				end
			end
			for (int j = 0; j < k; j++)
				push(j, cen_x[j], cen_y[j], acc_n[j], passes, conv, j + 1 == k);
		endfunction

		function void note_request(request_t r);
			int unsigned c;
			case (r.req_type)
				REQ_CLEAR: clear_work();
				REQ_LOAD_POINT: if (n_points < NPTS) begin
					pt_x[n_points] = r.coord_x;
					pt_y[n_points] = r.coord_y;
					n_points++;
				end
				REQ_LOAD_SEED: if (n_seeds < NCLU) begin
					cen_x[n_seeds] = longint'(r.coord_x) * 256;
					cen_y[n_seeds] = longint'(r.coord_y) * 256;
					n_seeds++;
				end
				REQ_RUN: lloyd_run();
				REQ_QUERY: if (r.point_index < n_points) begin
					c = member_of[r.point_index] % NCLU;
					push(c, cen_x[c], cen_y[c], acc_n[c], 0, 0, 1);
				end else
					push(0, 0, 0, 0, 0, 0, 1);
				default: ;
			endcase
		endfunction

		function void check_result(result_t got);
			result_t e;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result cluster=%0d mean=(%h,%h) count=%0d", $time,
					got.cluster_index, got.mean_x, got.mean_y, got.member_count);
				return;
			end
			e = expected_results.pop_front();
			if (got.cluster_index !== e.cluster_index || got.mean_x !== e.mean_x ||
					got.mean_y !== e.mean_y || got.member_count !== e.member_count ||
					got.passes_done !== e.passes_done || got.converged !== e.converged ||
					got.last !== e.last) begin
				errors++;
				$display("%0t: mismatch exp c=%0d mx=%h my=%h n=%0d p=%0d cv=%b l=%b", $time,
					e.cluster_index, e.mean_x, e.mean_y, e.member_count, e.passes_done,
					e.converged, e.last);
				$display("%0t:          got c=%0d mx=%h my=%h n=%0d p=%0d cv=%b l=%b", $time,
					got.cluster_index, got.mean_x, got.mean_y, got.member_count,
					got.passes_done, got.converged, got.last);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	bit tx_gaps;
	bit rx_gaps;
	int unsigned cycles;
	km_scoreboard sb;

	km_req_if #(.COORD_BITS(16), .PIDX_W(8)) req_ch ();
	km_res_if res_ch ();

	kmeans_2d_clustering u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.req(req_ch),
		.res(res_ch)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// result side: random stalls, one check per transaction
	initial begin
		result_t got;
		int n;
		res_ch.ready = 0;
		@(posedge arst_n);
		forever begin
			n = rx_gaps ? $urandom_range(0, 6) : 0;
			if (n > 0) begin
				res_ch.ready <= 0;
				repeat (n) @(posedge clk);
			end
			res_ch.ready <= 1;
			do @(posedge clk); while (!res_ch.valid);
			got.cluster_index = res_ch.cluster_index;
			got.mean_x = res_ch.mean_x;
			got.mean_y = res_ch.mean_y;
			got.member_count = res_ch.member_count;
			got.passes_done = res_ch.passes_done;
			got.converged = res_ch.converged;
			got.last = res_ch.last;
			sb.check_result(got);
		end
	end

	task automatic send(req_t t, int x, int y, int idx);
		request_t r;
		int n;
		n = tx_gaps ? $urandom_range(0, 6) : 0;
		if (n > 0) begin
			req_ch.valid <= 0;
			repeat (n) @(posedge clk);
		end
		r.req_type = t;
		r.coord_x = x[15:0];
		r.coord_y = y[15:0];
		r.point_index = idx[7:0];
		req_ch.valid <= 1;
		req_ch.req_type <= r.req_type;
		req_ch.coord_x <= r.coord_x;
		req_ch.coord_y <= r.coord_y;
		req_ch.point_index <= r.point_index;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(r);
	endtask

	task automatic wait_idle();
		req_ch.valid <= 0;
		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int v);
		wait_idle();
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= v[7:0];
		@(posedge clk);
		cfg_we <= 0;
		sb.write_config(idx, v[7:0]);
	endtask

	function automatic int clamp16(int v);
		return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
	endfunction

	function automatic int rnd16();
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	initial begin
		int seeds_x[NCLU];
		int seeds_y[NCLU];
		int ns, np, c;
		sb = new();
		cycles = 0;
		tx_gaps = 0;
		rx_gaps = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = REG_CLUSTER_COUNT;
		cfg_wdata = 0;
		req_ch.valid = 0;
		req_ch.req_type = REQ_CLEAR;
		req_ch.coord_x = 0;
		req_ch.coord_y = 0;
		req_ch.point_index = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: all means written once, extremes, overflow and odd requests
		send(REQ_QUERY, 0, 0, 0);
		for (int j = 0; j < 9; j++)
			send(REQ_LOAD_SEED, j == 0 ? -32768 : (j == 1 ? 32767 : j * 1000 - 4000),
				j == 0 ? 32767 : (j == 1 ? -32768 : 3000 - j * 700), 0);
		send(REQ_RUN, 0, 0, 0);
		send(REQ_LOAD_POINT, -32768, -32768, 0);
		send(REQ_LOAD_POINT, 32767, 32767, 0);
		send(REQ_LOAD_POINT, -32768, 32767, 0);
		send(REQ_LOAD_POINT, 0, 0, 0);
		send(req_t'(5), 1, 1, 1);
		send(req_t'(6), 0, 0, 0);
		send(req_t'(7), -1, -1, 255);
		write_reg(REG_CLUSTER_COUNT, 8);
		write_reg(REG_ITERATION_LIMIT, 0);
		send(REQ_RUN, 0, 0, 0);
		send(REQ_QUERY, 0, 0, 3);
		send(REQ_QUERY, 0, 0, 4);
		send(REQ_QUERY, 0, 0, 255);
		write_reg(REG_CLUSTER_COUNT, 0);
		write_reg(REG_ITERATION_LIMIT, 255);
		send(REQ_RUN, 0, 0, 0);
		write_reg(REG_CLUSTER_COUNT, 15);
		send(REQ_RUN, 0, 0, 0);
		send(REQ_CLEAR, 0, 0, 0);
		send(REQ_QUERY, 0, 0, 0);

		// random sessions: seeds, clustered points, run, queries, some noise
		for (int ep = 0; ep < 7; ep++) begin
			tx_gaps = $urandom_range(0, 2) != 0;
			rx_gaps = $urandom_range(0, 2) != 0;
			wait_idle();
			if ($urandom_range(0, 1)) write_reg(REG_CLUSTER_COUNT, $urandom_range(0, 15));
			if ($urandom_range(0, 1))
				write_reg(REG_ITERATION_LIMIT, $urandom_range(0, 3) == 0 ?
					$urandom_range(0, 255) : $urandom_range(1, 12));
			send(REQ_CLEAR, rnd16(), rnd16(), $urandom_range(0, 255));
			ns = $urandom_range(1, 8);
			for (int j = 0; j < ns; j++) begin
				seeds_x[j] = $urandom_range(0, 3) == 0 ? rnd16() : rnd16() / 2;
				seeds_y[j] = $urandom_range(0, 3) == 0 ? rnd16() : rnd16() / 2;
				send(REQ_LOAD_SEED, seeds_x[j], seeds_y[j], 0);
			end
			np = $urandom_range(0, 12);
			for (int i = 0; i < np; i++) begin
				c = $urandom_range(0, ns - 1);
				if ($urandom_range(0, 5) == 0)
					send(REQ_LOAD_POINT, rnd16(), rnd16(), $urandom_range(0, 255));
				else
					send(REQ_LOAD_POINT,
						clamp16(seeds_x[c] + int'($urandom_range(0, 2000)) - 1000),
						clamp16(seeds_y[c] + int'($urandom_range(0, 2000)) - 1000), 0);
			end
			if ($urandom_range(0, 4) == 0) send(req_t'($urandom_range(5, 7)), rnd16(), 0, 0);
			send(REQ_RUN, 0, 0, 0);
			for (int q = 0; q < 3; q++)
				send(REQ_QUERY, rnd16(), rnd16(), $urandom_range(0, 3) == 0 ?
					$urandom_range(0, 255) : $urandom_range(0, np));
			if ($urandom_range(0, 1)) send(REQ_RUN, 0, 0, 0);
		end

		wait_idle();
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.expected_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
